>>> rtl/swam_pkg.sv
`default_nettype none
package swam_pkg;

    localparam int ALPHABET    = 26;
    localparam int MAX_PATTERN = 256;

    localparam int LETTER_W = 5;
    localparam int CMD_W    = 2;
    localparam int CNT_W    = $clog2(MAX_PATTERN + 1);
    localparam int RING_W   = $clog2(MAX_PATTERN);

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [RING_W-1:0]   t_ring;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PATTERN = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/swam_ram.sv
`default_nettype none
module swam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/sliding_window_anagram_match_top.sv
// Sliding-window anagram search over a stream of letter indices.
// Input channel: i_in_valid / o_in_stall with i_command and i_letter. A
// transaction is taken at a clock edge where i_in_valid is high and o_in_stall
// is low. Commands: clear all, add a pattern letter (also restarts the text),
// add a text letter, restart the text.
// Output channel: o_out_valid / i_out_stall with o_window_match, o_found and
// o_status; exactly one result transaction per input transaction, in order.
// The result is registered by the edge that takes the input transaction.
// Throughput: one transaction per cycle while the receiver does not stall; the
// 26 bin updates and compares are combinational, and the eviction letter is
// prefetched from the history RAM, with a bypass for a same-cycle write.
// When the receiver stalls, the output register holds its result and
// o_in_stall rises while it stays full; it falls in the cycle the result goes.
// Reset (i_rst_n low, synchronous) clears all counts, the pattern, the window,
// the found flag and the output valid; the history RAM needs no clearing.
`default_nettype none
module sliding_window_anagram_match_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [swam_pkg::CMD_W-1:0]    i_command,
    input  wire logic [swam_pkg::LETTER_W-1:0] i_letter,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_window_match,
    output logic                          o_found,
    output logic                          o_status
);
    import swam_pkg::*;

    t_count  r_pcnt [ALPHABET];
    t_count  r_wcnt [ALPHABET];
    t_count  n_pcnt [ALPHABET];
    t_count  n_wcnt [ALPHABET];
    t_count  r_plen, n_plen;
    t_count  r_fill, n_fill;
    t_ring   r_ring, n_ring;
    logic    r_found, n_found;

    logic    r_byp_hit;
    t_letter r_byp_letter;
    t_letter ram_rd_data;
    t_letter gone;
    t_ring   rd_addr;
    logic    wr_en;

    logic    accept;
    logic    match, status;
    logic    all_eq;
    logic    letter_ok, gone_ok, evict;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign gone      = r_byp_hit ? r_byp_letter : ram_rd_data;
    assign letter_ok = i_letter < LETTER_W'(ALPHABET);
    assign gone_ok   = gone < LETTER_W'(ALPHABET);
    assign evict     = r_fill >= r_plen;

    always_comb begin
        n_pcnt  = r_pcnt;
        n_wcnt  = r_wcnt;
        n_plen  = r_plen;
        n_fill  = r_fill;
        n_ring  = r_ring;
        n_found = r_found;
        match   = 1'b0;
        status  = 1'b0;
        wr_en   = 1'b0;
        all_eq  = 1'b1;
        if (accept) begin
            case (t_cmd'(i_command))
                CMD_CLEAR: begin
                    for (int i = 0; i < ALPHABET; i++) begin
                        n_pcnt[i] = '0;
                        n_wcnt[i] = '0;
                    end
                    n_plen  = '0;
                    n_fill  = '0;
                    n_ring  = '0;
                    n_found = 1'b0;
                end
                CMD_PATTERN: begin
                    for (int i = 0; i < ALPHABET; i++) begin
                        n_wcnt[i] = '0;
                    end
                    n_fill  = '0;
                    n_ring  = '0;
                    n_found = 1'b0;
                    if (r_plen >= CNT_W'(MAX_PATTERN) || !letter_ok) begin
                        status = 1'b1;
                    end else begin
                        for (int i = 0; i < ALPHABET; i++) begin
                            if (i_letter == LETTER_W'(i)) begin
                                n_pcnt[i] = r_pcnt[i] + CNT_W'(1);
                            end
                        end
                        n_plen = r_plen + CNT_W'(1);
                    end
                end
                CMD_TEXT: begin
                    if (r_plen != '0) begin
                        wr_en = 1'b1;
                        if (evict) begin
                            n_fill = r_plen;
                        end else begin
                            n_fill = r_fill + CNT_W'(1);
                        end
                        for (int i = 0; i < ALPHABET; i++) begin
                            n_wcnt[i] = r_wcnt[i]
                                - CNT_W'(evict && gone_ok && gone == LETTER_W'(i)
                                         && r_wcnt[i] != '0)
                                + CNT_W'(letter_ok && i_letter == LETTER_W'(i));
                            if (n_wcnt[i] != r_pcnt[i]) begin
                                all_eq = 1'b0;
                            end
                        end
                        n_ring = r_ring + RING_W'(1);
                        match  = all_eq && (n_fill == r_plen);
                        if (match) begin
                            n_found = 1'b1;
                        end
                    end
                end
                CMD_RESTART: begin
                    for (int i = 0; i < ALPHABET; i++) begin
                        n_wcnt[i] = '0;
                    end
                    n_fill  = '0;
                    n_ring  = '0;
                    n_found = 1'b0;
                end
                default: begin
                    n_found = r_found;
                end
            endcase
        end
    end

    // oldest slot for the next text letter, read ahead of it
    assign rd_addr = n_ring - n_plen[RING_W-1:0];

    swam_ram #(
        .WIDTH(LETTER_W),
        .DEPTH(MAX_PATTERN)
    ) u_ring (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_ring),
        .i_wr_data(i_letter),
        .i_rd_addr(rd_addr),
        .o_rd_data(ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_byp_letter <= i_letter;
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_fill      <= '0;
            r_ring      <= '0;
            r_found     <= 1'b0;
            r_byp_hit   <= 1'b0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_pcnt[i] <= '0;
                r_wcnt[i] <= '0;
            end
        end else begin
            r_plen    <= n_plen;
            r_fill    <= n_fill;
            r_ring    <= n_ring;
            r_found   <= n_found;
            r_pcnt    <= n_pcnt;
            r_wcnt    <= n_wcnt;
            r_byp_hit <= wr_en && (r_ring == rd_addr);
            if (accept) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_window_match <= match;
            o_found        <= n_found;
            o_status       <= status;
        end
    end

endmodule
`default_nettype wire
